@@ rtl/f5me_pkg.sv @@
package f5me_pkg;
  localparam int MAX_K = 7;
  localparam int COEFF_BITS = 12;
  localparam int POSITION_BITS = 20;
  localparam int DEPTH = (1 << MAX_K) - 1;
  localparam int IDX_W = MAX_K;
  localparam int ENTRY_W = COEFF_BITS + POSITION_BITS;

  localparam logic [1:0] KIND_WB = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_PARTIAL = 2'd2;
  localparam logic [1:0] KIND_CLEAN = 2'd3;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_KBITS = 1'b1;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic [IDX_W-1:0]    raddr;
  } mem_req_t;
endpackage

@@ rtl/f5me_store.sv @@
module f5me_store
  import f5me_pkg::*;
(
  input  logic               clk,
  input  mem_req_t           req,
  output logic [ENTRY_W-1:0] rdata
);
  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

@@ rtl/f5me_ctrl.sv @@
module f5me_ctrl
  import f5me_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [2:0]               cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [COEFF_BITS-1:0] in_coefficient,
  input  logic [POSITION_BITS-1:0] in_position,
  input  logic [6:0]               in_message_bits,
  input  logic                     in_flush,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_kind,
  output logic [POSITION_BITS-1:0] out_position,
  output logic signed [COEFF_BITS-1:0] out_new_value,
  output logic [6:0]               out_extracted_bits,
  output logic                     out_last,
  output mem_req_t                 mreq,
  input  logic [ENTRY_W-1:0]       mrdata
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_MOD, S_SHIFT, S_SYN, S_OUT2} state_t;

  state_t state_r;
  logic mode_r;
  logic [2:0] kcfg_r;
  logic [IDX_W-1:0] fill_r, held_r, syn_r, ptr_r;
  logic retry_r;

  logic [2:0] k_eff;
  logic [IDX_W-1:0] kmask;
  logic [IDX_W:0] n_full;
  logic accept, ovf_q;
  logic [IDX_W-1:0] slot, fill_inc, idx;
  logic signed [COEFF_BITS-1:0] rd_c, dec_c;
  logic [POSITION_BITS-1:0] rd_p;

  always_comb begin
    k_eff = kcfg_r;
    if (kcfg_r < 3'd2) k_eff = 3'd2;
    if ({29'd0, kcfg_r} > MAX_K) k_eff = 3'(MAX_K);
  end
  assign kmask = IDX_W'((1 << k_eff) - 1);
  assign n_full = {1'b0, kmask};
  assign in_ready = (state_r == S_IDLE) && !out_valid;
  assign accept = in_valid && in_ready;
  assign ovf_q = (fill_r == IDX_W'(DEPTH));
  assign slot = ovf_q ? IDX_W'(DEPTH - 1) : fill_r;
  assign fill_inc = slot + 1'b1;
  assign idx = (held_r ^ syn_r) & kmask;
  assign rd_c = mrdata[ENTRY_W-1 -: COEFF_BITS];
  assign rd_p = mrdata[POSITION_BITS-1:0];
  assign dec_c = (rd_c > 0) ? rd_c - 1'b1 : rd_c + 1'b1;

  // memory port mux
  always_comb begin
    mreq = '0;
    mreq.raddr = ptr_r;
    if (accept && !in_flush && in_coefficient != '0) begin
      mreq.we = 1'b1;
      mreq.waddr = slot;
      mreq.wdata = {in_coefficient, in_position};
    end else if (state_r == S_SHIFT) begin
      // mrdata holds entry ptr_r read last cycle; write one slot lower
      mreq.we = 1'b1;
      mreq.waddr = ptr_r - 1'b1;
      mreq.wdata = mrdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r <= 1'b0;
      kcfg_r <= 3'd2;
      fill_r <= '0;
      held_r <= '0;
      syn_r <= '0;
      retry_r <= 1'b0;
      ptr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_OUT2 the first beat hands over directly to the second
      if (out_valid && out_ready && state_r != S_OUT2) out_valid <= 1'b0;
      if (cfg_we && cfg_index == {2'b0, CFG_MODE}) mode_r <= cfg_wdata[0];
      if (cfg_we && cfg_index == {2'b0, CFG_KBITS}) begin
        kcfg_r <= cfg_wdata;
        fill_r <= '0;
        syn_r <= '0;
        retry_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_flush) begin
              out_valid <= 1'b1;
              out_kind <= (fill_r != '0 || retry_r) ? KIND_PARTIAL : KIND_CLEAN;
              out_position <= '0;
              out_new_value <= '0;
              out_extracted_bits <= '0;
              out_last <= 1'b1;
              fill_r <= '0;
              syn_r <= '0;
              retry_r <= 1'b0;
            end else if (in_coefficient != '0) begin
              logic [IDX_W-1:0] nsyn;
              logic [IDX_W-1:0] nheld;
              nheld = (fill_r == '0 && !retry_r) ? in_message_bits[IDX_W-1:0] & kmask
                                                 : held_r;
              nsyn = (syn_r ^ (in_coefficient[0] ? fill_inc : '0)) & kmask;
              held_r <= nheld;
              syn_r <= nsyn;
              fill_r <= fill_inc;
              if ({1'b0, fill_inc} >= n_full) begin
                out_position <= '0;
                out_new_value <= '0;
                out_last <= 1'b1;
                out_kind <= KIND_DONE;
                if (mode_r) begin
                  out_valid <= 1'b1;
                  out_extracted_bits <= 7'(nsyn);
                  fill_r <= '0; syn_r <= '0; retry_r <= 1'b0;
                end else if (((nheld ^ nsyn) & kmask) == '0) begin
                  out_valid <= 1'b1;
                  out_extracted_bits <= '0;
                  fill_r <= '0; syn_r <= '0; retry_r <= 1'b0;
                end else begin
                  ptr_r <= ((nheld ^ nsyn) & kmask) - 1'b1;
                  state_r <= S_READ;
                end
              end
            end
          end
        end
        S_READ: state_r <= S_MOD;
        S_MOD: begin
          out_valid <= 1'b1;
          out_kind <= KIND_WB;
          out_position <= rd_p;
          out_new_value <= dec_c;
          out_extracted_bits <= '0;
          if (dec_c != '0) begin
            out_last <= 1'b0;
            fill_r <= '0; syn_r <= '0; retry_r <= 1'b0;
            state_r <= S_OUT2;
          end else begin
            out_last <= 1'b1;
            retry_r <= 1'b1;
            fill_r <= fill_r - 1'b1;
            // syndrome: remove slot idx, slots above shift down by one
            syn_r <= syn_r ^ idx;
            ptr_r <= ptr_r + 1'b1;
            state_r <= (ptr_r + 1'b1 < fill_r) ? S_SYN : S_IDLE;
          end
        end
        S_SYN: state_r <= S_SHIFT; // read of ptr_r in flight
        S_SHIFT: begin
          // entry at ptr_r moved to ptr_r-1: syndrome term ptr_r+1 -> ptr_r
          if (mrdata[COEFF_BITS+POSITION_BITS-COEFF_BITS])
            syn_r <= (syn_r ^ (ptr_r + 1'b1) ^ ptr_r) & kmask;
          ptr_r <= ptr_r + 1'b1;
          state_r <= (ptr_r + 1'b1 <= fill_r) ? S_SYN : S_IDLE;
        end
        S_OUT2: begin
          if (out_ready) begin
            out_kind <= KIND_DONE;
            out_position <= '0;
            out_new_value <= '0;
            out_last <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/f5_matrix_embed_extract.sv @@
// channel  dir  beat contents
// cfg      in   cfg_we, cfg_index, cfg_wdata
// in       in   coefficient, position, message_bits, flush
// out      out  kind, out_position, new_value, extracted_bits, last
// An append is taken only in S_IDLE while the output register is empty.
// A modified group reads its slot; shrinkage then walks the upper part
// of the group store, each entry through S_SYN and S_SHIFT, via the
// single read port. Reset is synchronous; the store needs no clearing.
module f5_matrix_embed_extract
  import f5me_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [2:0]                   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COEFF_BITS-1:0] in_coefficient,
  input  logic [POSITION_BITS-1:0]     in_position,
  input  logic [6:0]                   in_message_bits,
  input  logic                         in_flush,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_kind,
  output logic [POSITION_BITS-1:0]     out_position,
  output logic signed [COEFF_BITS-1:0] out_new_value,
  output logic [6:0]                   out_extracted_bits,
  output logic                         out_last
);
  mem_req_t mreq;
  logic [ENTRY_W-1:0] mrdata;

  f5me_store u_store (.clk, .req(mreq), .rdata(mrdata));

  f5me_ctrl u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_coefficient, .in_position, .in_message_bits, .in_flush,
    .out_valid, .out_ready, .out_kind, .out_position, .out_new_value,
    .out_extracted_bits, .out_last, .mreq, .mrdata
  );
endmodule

@@ tb/sv/f5_matrix_embed_extract_tb.sv @@
module f5_matrix_embed_extract_tb;
  import f5me_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_MODE    = 3'(CFG_MODE);
  localparam logic [2:0] REG_KBITS   = 3'(CFG_KBITS);
  localparam logic [2:0] REG_UNUSED  = 3'd5;
  localparam logic [2:0] REG_TOP     = 3'd7;
  localparam logic       MODE_EMBED   = 1'b0;
  localparam logic       MODE_EXTRACT = 1'b1;
  localparam int         DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [1:0]                   kind;
    logic [POSITION_BITS-1:0]     pos;
    logic signed [COEFF_BITS-1:0] value;
    logic [6:0]                   bits;
    logic                         last;
  } f5_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [2:0]                   cfg_index = '0;
  logic [2:0]                   cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [COEFF_BITS-1:0] in_coefficient = '0;
  logic [POSITION_BITS-1:0]     in_position = '0;
  logic [6:0]                   in_message_bits = '0;
  logic                         in_flush = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   out_kind;
  logic [POSITION_BITS-1:0]     out_position;
  logic signed [COEFF_BITS-1:0] out_new_value;
  logic [6:0]                   out_extracted_bits;
  logic                         out_last;

  f5_matrix_embed_extract dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic signed [COEFF_BITS-1:0] grp_coef [DEPTH];
  logic [POSITION_BITS-1:0]     grp_pos [DEPTH];
  int unsigned                  grp_fill;
  logic [6:0]                   grp_msg;
  logic                         grp_retry;
  logic [6:0]                   grp_synd;
  logic                         cur_mode;
  logic [2:0]                   cur_kbits;

  f5_result_t pending_results[$];
  int err_count = 0;
  int n_items = 0;
  int n_results = 0;
  int n_shrink = 0;
  logic calm = 1'b0;
  logic sink_pause_req = 1'b0;
  logic sink_pause_done = 1'b0;
  logic out_beat = 1'b0;

  function automatic f5_result_t mk(logic [1:0] kind, logic [POSITION_BITS-1:0] pos,
                                    logic signed [COEFF_BITS-1:0] v, logic [6:0] b,
                                    logic last);
    f5_result_t r;
    r.kind = kind; r.pos = pos; r.value = v; r.bits = b; r.last = last;
    return r;
  endfunction

  function automatic void clear_group();
    grp_fill = 0;
    grp_synd = '0;
    grp_retry = 1'b0;
  endfunction

  function automatic void f5_predict(logic signed [COEFF_BITS-1:0] coef,
                                     logic [POSITION_BITS-1:0] pos,
                                     logic [6:0] msg, logic flush);
    int unsigned k, n, idx, i;
    logic [6:0] kmask;
    int v;
    k = (cur_kbits < 2) ? 2 : cur_kbits;
    n = (1 << k) - 1;
    kmask = 7'((1 << k) - 1);
    if (flush) begin
      pending_results.push_back(mk((grp_fill > 0 || grp_retry) ? KIND_PARTIAL : KIND_CLEAN,
                                   '0, '0, '0, 1'b1));
      clear_group();
      return;
    end
    if (coef == 0) return;
    if (grp_fill == 0 && !grp_retry) grp_msg = msg & kmask;
    grp_coef[grp_fill] = coef;
    grp_pos[grp_fill] = pos;
    if (coef[0]) grp_synd ^= 7'(grp_fill + 1);
    grp_synd &= kmask;
    grp_fill++;
    if (grp_fill < n) return;
    if (cur_mode == MODE_EXTRACT) begin
      pending_results.push_back(mk(KIND_DONE, '0, '0, grp_synd, 1'b1));
      clear_group();
      return;
    end
    idx = (grp_msg ^ grp_synd) & kmask;
    if (idx == 0) begin
      pending_results.push_back(mk(KIND_DONE, '0, '0, '0, 1'b1));
      clear_group();
      return;
    end
    i = idx - 1;
    v = grp_coef[i];
    v = (v > 0) ? v - 1 : v + 1;
    if (v != 0) begin
      pending_results.push_back(mk(KIND_WB, grp_pos[i], COEFF_BITS'(v), '0, 1'b0));
      pending_results.push_back(mk(KIND_DONE, '0, '0, '0, 1'b1));
      clear_group();
      return;
    end
    // shrinkage: drop the slot, close the gap, redo the syndrome
    n_shrink++;
    pending_results.push_back(mk(KIND_WB, grp_pos[i], '0, '0, 1'b1));
    for (; i + 1 < grp_fill; i++) begin
      grp_coef[i] = grp_coef[i+1];
      grp_pos[i] = grp_pos[i+1];
    end
    grp_fill--;
    grp_synd = '0;
    for (i = 0; i < grp_fill; i++)
      if (grp_coef[i][0]) grp_synd ^= 7'(i + 1);
    grp_synd &= kmask;
    grp_retry = 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    f5_result_t exp_r;
    out_beat = 1'b0;
    if (rst_n && out_valid && out_ready) begin
      out_beat = 1'b1;
      n_results++;
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result kind=%0d pos=%0d val=%0d bits=%0d last=%0d",
                 $time, out_kind, out_position, out_new_value, out_extracted_bits, out_last);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_kind !== exp_r.kind) begin
          err_count++;
          $display("%0t: kind exp %0d got %0d", $time, exp_r.kind, out_kind);
        end
        if (out_position !== exp_r.pos) begin
          err_count++;
          $display("%0t: position exp %0d got %0d", $time, exp_r.pos, out_position);
        end
        if (out_new_value !== exp_r.value) begin
          err_count++;
          $display("%0t: new_value exp %0d got %0d", $time, exp_r.value, out_new_value);
        end
        if (out_extracted_bits !== exp_r.bits) begin
          err_count++;
          $display("%0t: bits exp %0d got %0d", $time, exp_r.bits, out_extracted_bits);
        end
        if (out_last !== exp_r.last) begin
          err_count++;
          $display("%0t: last exp %0d got %0d", $time, exp_r.last, out_last);
        end
      end
    end
  end

  // receiver: random stalls after some beats, one long hold-off on request
  int sink_wait = 0;
  int pause_cnt = 0;
  always @(negedge clk) begin
    if (sink_pause_req && !sink_pause_done) begin
      out_ready <= 1'b0;
      pause_cnt++;
      if (pause_cnt == 400) sink_pause_done <= 1'b1;
    end else if (out_beat && !calm && sink_wait == 0 && $urandom_range(0, 1)) begin
      sink_wait = $urandom_range(1, 6);
      out_ready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      out_ready <= (sink_wait == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_beat(logic signed [COEFF_BITS-1:0] coef, logic [POSITION_BITS-1:0] pos,
                           logic [6:0] msg, logic flush);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_coefficient <= coef;
    in_position <= pos;
    in_message_bits <= msg;
    in_flush <= flush;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    f5_predict(coef, pos, msg, flush);
    n_items++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [2:0] val);
    go_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) cur_mode = val[0];
    else if (idx == REG_KBITS) begin
      cur_kbits = val;
      clear_group();
    end
  endtask

  function automatic logic signed [COEFF_BITS-1:0] rand_coef();
    int sel;
    int m;
    sel = $urandom_range(0, 99);
    if (sel < 12) return '0;
    if (sel < 60) m = $urandom_range(1, 2);
    else if (sel < 88) m = $urandom_range(1, 15);
    else return COEFF_BITS'($urandom);
    return $urandom_range(0, 1) ? COEFF_BITS'(m) : COEFF_BITS'(-m);
  endfunction

  task automatic send_random(int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 3) send_beat(rand_coef(), POSITION_BITS'($urandom), 7'($urandom), 1'b1);
      else send_beat(rand_coef(), POSITION_BITS'($urandom), 7'($urandom), 1'b0);
    end
  endtask

  task automatic test_directed();
    // k=2, embed: groups of three nonzero coefficients
    send_beat(12'sd2047, '0, 7'h7F, 1'b0);
    send_beat(-12'sd2048, 20'hFFFFF, 7'h00, 1'b0);
    send_beat('0, 20'h12345, 7'h00, 1'b0);
    send_beat(12'sd1, 20'h00001, 7'h00, 1'b0);
    // zero embed index: syndrome of {odd,even,even} is 1, message 1
    send_beat(12'sd1, 20'h00010, 7'h01, 1'b0);
    send_beat(12'sd2, 20'h00011, 7'h00, 1'b0);
    send_beat(12'sd2, 20'h00012, 7'h00, 1'b0);
    send_beat(-12'sd1, 20'h00013, 7'h00, 1'b0);
    // {-1,3,4} with message 0: index 3, so the 4 is written back as 3
    send_beat(12'sd3, 20'h00020, 7'h01, 1'b0);
    send_beat(12'sd4, 20'h00021, 7'h00, 1'b0);
    send_beat(-12'sd6, 20'h00022, 7'h00, 1'b0);
    send_beat(12'sd5, 20'h00030, 7'h02, 1'b0);
    send_beat('0, '0, '0, 1'b1);
    send_beat('0, '0, '0, 1'b1);
    cfg_write(REG_KBITS, 3'd0);
    send_beat(-12'sd2048, 20'hABCDE, 7'h03, 1'b0);
    send_beat(-12'sd2048, 20'h54321, 7'h03, 1'b0);
    cfg_write(REG_UNUSED, 3'd7);
    cfg_write(REG_TOP, 3'd1);
    cfg_write(REG_MODE, MODE_EXTRACT);
    send_beat(12'sd7, 20'h00040, 7'h00, 1'b0);
    send_beat(-12'sd3, 20'h00041, 7'h00, 1'b0);
    send_beat(12'sd9, 20'h00042, 7'h00, 1'b0);
    cfg_write(REG_KBITS, 3'd1);
    send_beat(12'sd1, 20'h00050, 7'h00, 1'b0);
    send_beat('0, '0, '0, 1'b1);
    cfg_write(REG_MODE, MODE_EMBED);
  endtask

  task automatic test_embed_random();
    cfg_write(REG_KBITS, 3'd2);
    send_random(300);
    calm = 1'b1;
    cfg_write(REG_KBITS, 3'd3);
    send_random(150);
    calm = 1'b0;
    send_random(150);
    cfg_write(REG_KBITS, 3'd4);
    send_random(250);
    cfg_write(REG_KBITS, 3'd5);
    send_random(120);
    cfg_write(REG_KBITS, 3'd7);
    send_random(140);
  endtask

  task automatic test_extract_random();
    cfg_write(REG_MODE, MODE_EXTRACT);
    cfg_write(REG_KBITS, 3'd3);
    send_random(150);
    cfg_write(REG_KBITS, 3'd6);
    send_random(100);
    cfg_write(REG_MODE, MODE_EMBED);
  endtask

  task automatic test_backpressure();
    cfg_write(REG_KBITS, 3'd2);
    sink_pause_req = 1'b1;
    send_random(90);
  endtask

  initial begin
    cur_mode = MODE_EMBED;
    cur_kbits = 3'd2;
    grp_msg = '0;
    clear_group();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_embed_random();
    test_extract_random();
    test_backpressure();
    go_idle();
    $display("Sent %0d beats in embed and extract modes, k from 2 to 7, with flushes and stalls.",
             n_items);
    $display("Checked %0d results, %0d of them shrinkage write-backs.", n_results, n_shrink);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
